/* hw/rtl/npr_pkg.sv */
// Shared types and constants for the nearest point in rectangles block.
package npr_pkg;

    localparam int REGION_SLOTS = 8;
    localparam int COORD_BITS   = 16;
    localparam int SIZE_BITS    = COORD_BITS - 1;
    localparam int SLOT_BITS    = 3;
    localparam int CMD_BITS     = 2;
    localparam int DIST_BITS    = 2 * COORD_BITS + 2;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_WRITE = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_QUERY = 2'd2
    } cmd_t;

    // One beat as it travels down the row of cells.
    typedef struct packed {
        logic                         valid;
        logic [CMD_BITS-1:0]          cmd;
        logic [SLOT_BITS-1:0]         slot;
        logic signed [COORD_BITS-1:0] rect_left;
        logic signed [COORD_BITS-1:0] rect_top;
        logic [SIZE_BITS-1:0]         rect_width;
        logic [SIZE_BITS-1:0]         rect_height;
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic                         found;
        logic [DIST_BITS-1:0]         best_dist;
        logic signed [COORD_BITS-1:0] best_x;
        logic signed [COORD_BITS-1:0] best_y;
    } tok_t;

endpackage

/* hw/rtl/npr_cell.sv */
// One table slot: holds a rectangle and folds it into a passing query in three stages.
module npr_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          advance,
    input  logic          sel,
    input  npr_pkg::tok_t tok_in,
    output npr_pkg::tok_t tok_out
);

    localparam int CW = npr_pkg::COORD_BITS;
    localparam int DW = npr_pkg::DIST_BITS;

    logic                 rect_valid_reg;
    logic signed [CW-1:0] lo_x_reg;
    logic signed [CW-1:0] lo_y_reg;
    logic signed [CW:0]   hi_x_reg;
    logic signed [CW:0]   hi_y_reg;

    logic                 is_write;
    logic                 is_clear;
    logic                 is_query;
    logic [npr_pkg::SIZE_BITS-1:0] w_fix;
    logic [npr_pkg::SIZE_BITS-1:0] h_fix;
    logic signed [CW:0]   wr_lo_x;
    logic signed [CW:0]   wr_lo_y;

    logic signed [CW:0]   px_w;
    logic signed [CW:0]   py_w;
    logic signed [CW:0]   lox_w;
    logic signed [CW:0]   loy_w;
    logic signed [CW:0]   dlo_x;
    logic signed [CW:0]   dlo_y;
    logic signed [CW:0]   dhi_x;
    logic signed [CW:0]   dhi_y;
    logic                 below_x;
    logic                 below_y;
    logic                 above_x;
    logic                 above_y;
    logic signed [CW-1:0] cand_x;
    logic signed [CW-1:0] cand_y;
    logic [CW-1:0]        adx;
    logic [CW-1:0]        ady;

    npr_pkg::tok_t        a_tok_reg;
    logic                 a_hit_reg;
    logic signed [CW-1:0] a_cx_reg;
    logic signed [CW-1:0] a_cy_reg;
    logic [CW-1:0]        a_dx_reg;
    logic [CW-1:0]        a_dy_reg;

    npr_pkg::tok_t        b_tok_reg;
    logic                 b_hit_reg;
    logic signed [CW-1:0] b_cx_reg;
    logic signed [CW-1:0] b_cy_reg;
    logic [2*CW-1:0]      b_sqx_reg;
    logic [2*CW-1:0]      b_sqy_reg;

    logic [DW-1:0]        sq_dist;
    logic                 take;
    npr_pkg::tok_t        tok_next;
    npr_pkg::tok_t        tok_out_reg;

    assign is_write = tok_in.valid && (tok_in.cmd == npr_pkg::CMD_WRITE);
    assign is_clear = tok_in.valid && (tok_in.cmd == npr_pkg::CMD_CLEAR);
    assign is_query = tok_in.valid && (tok_in.cmd == npr_pkg::CMD_QUERY);

    // A zero size is kept as a single pixel; the far edge is stored inclusive.
    assign w_fix   = (tok_in.rect_width == '0) ? npr_pkg::SIZE_BITS'(1) : tok_in.rect_width;
    assign h_fix   = (tok_in.rect_height == '0) ? npr_pkg::SIZE_BITS'(1) : tok_in.rect_height;
    assign wr_lo_x = {tok_in.rect_left[CW-1], tok_in.rect_left};
    assign wr_lo_y = {tok_in.rect_top[CW-1], tok_in.rect_top};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rect_valid_reg <= 1'b0;
        end
        else if (advance && sel && is_write)
        begin
            rect_valid_reg <= 1'b1;
        end
        else if (advance && sel && is_clear)
        begin
            rect_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && sel && is_write)
        begin
            lo_x_reg <= tok_in.rect_left;
            lo_y_reg <= tok_in.rect_top;
            hi_x_reg <= wr_lo_x + (CW+1)'(w_fix) - (CW+1)'(1);
            hi_y_reg <= wr_lo_y + (CW+1)'(h_fix) - (CW+1)'(1);
        end
    end

    // Stage A: clamp each axis and take the distance magnitude.
    assign px_w  = {tok_in.point_x[CW-1], tok_in.point_x};
    assign py_w  = {tok_in.point_y[CW-1], tok_in.point_y};
    assign lox_w = {lo_x_reg[CW-1], lo_x_reg};
    assign loy_w = {lo_y_reg[CW-1], lo_y_reg};

    assign below_x = px_w < lox_w;
    assign below_y = py_w < loy_w;
    assign above_x = px_w > hi_x_reg;
    assign above_y = py_w > hi_y_reg;
    assign dlo_x   = lox_w - px_w;
    assign dlo_y   = loy_w - py_w;
    assign dhi_x   = px_w - hi_x_reg;
    assign dhi_y   = py_w - hi_y_reg;

    always_comb
    begin
        cand_x = tok_in.point_x;
        adx    = '0;
        if (below_x)
        begin
            cand_x = lo_x_reg;
            adx    = dlo_x[CW-1:0];
        end
        else if (above_x)
        begin
            cand_x = hi_x_reg[CW-1:0];
            adx    = dhi_x[CW-1:0];
        end

        cand_y = tok_in.point_y;
        ady    = '0;
        if (below_y)
        begin
            cand_y = lo_y_reg;
            ady    = dlo_y[CW-1:0];
        end
        else if (above_y)
        begin
            cand_y = hi_y_reg[CW-1:0];
            ady    = dhi_y[CW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_tok_reg <= '0;
            a_hit_reg <= 1'b0;
            b_tok_reg <= '0;
            b_hit_reg <= 1'b0;
            tok_out_reg <= '0;
        end
        else if (advance)
        begin
            a_tok_reg   <= tok_in;
            a_hit_reg   <= is_query && rect_valid_reg;
            b_tok_reg   <= a_tok_reg;
            b_hit_reg   <= a_hit_reg;
            tok_out_reg <= tok_next;
        end
    end

    // Stage B: square both axis distances.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_cx_reg  <= cand_x;
            a_cy_reg  <= cand_y;
            a_dx_reg  <= adx;
            a_dy_reg  <= ady;
            b_cx_reg  <= a_cx_reg;
            b_cy_reg  <= a_cy_reg;
            b_sqx_reg <= a_dx_reg * a_dx_reg;
            b_sqy_reg <= a_dy_reg * a_dy_reg;
        end
    end

    // Stage C: sum; take the first hit, else only a strictly smaller distance.
    assign sq_dist = DW'(b_sqx_reg) + DW'(b_sqy_reg);
    assign take    = b_hit_reg && (!b_tok_reg.found || (sq_dist < b_tok_reg.best_dist));

    always_comb
    begin
        tok_next = b_tok_reg;
        if (take)
        begin
            tok_next.found     = 1'b1;
            tok_next.best_dist = sq_dist;
            tok_next.best_x    = b_cx_reg;
            tok_next.best_y    = b_cy_reg;
        end
    end

    assign tok_out = tok_out_reg;

endmodule

/* hw/rtl/nearest_point_in_rectangles_top.sv */
// Top level: a row of rectangle cells that every beat walks through, then a result register.
// Every beat passes three stages per slot; a finished query is then loaded into the result
// register, which drives rsp_valid. The row is pipelined, so a new beat of any kind is taken
// in every cycle unless req_stall holds the row for a blocked result.
// Writes and clears travel the same row, so they act on the table in beat order.
// Reset clears every slot's valid bit and empties the row and the result register.
module nearest_point_in_rectangles_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 req_valid,
    output logic                                 req_stall,
    input  logic [npr_pkg::CMD_BITS-1:0]         command,
    input  logic [npr_pkg::SLOT_BITS-1:0]        slot,
    input  logic signed [npr_pkg::COORD_BITS-1:0] rect_left,
    input  logic signed [npr_pkg::COORD_BITS-1:0] rect_top,
    input  logic [npr_pkg::SIZE_BITS-1:0]        rect_width,
    input  logic [npr_pkg::SIZE_BITS-1:0]        rect_height,
    input  logic signed [npr_pkg::COORD_BITS-1:0] point_x,
    input  logic signed [npr_pkg::COORD_BITS-1:0] point_y,
    output logic                                 rsp_valid,
    input  logic                                 rsp_stall,
    output logic signed [npr_pkg::COORD_BITS-1:0] result_x,
    output logic signed [npr_pkg::COORD_BITS-1:0] result_y,
    output logic                                 no_region
);

    localparam int N  = npr_pkg::REGION_SLOTS;
    localparam int CW = npr_pkg::COORD_BITS;

    npr_pkg::tok_t        chain [0:N];
    logic [N-1:0]         sel;
    logic                 advance;
    logic                 last_query;

    logic                 rsp_valid_reg;
    logic                 rsp_valid_next;
    logic signed [CW-1:0] result_x_reg;
    logic signed [CW-1:0] result_y_reg;
    logic                 no_region_reg;

    always_comb
    begin
        chain[0].valid       = req_valid;
        chain[0].cmd         = command;
        chain[0].slot        = slot;
        chain[0].rect_left   = rect_left;
        chain[0].rect_top    = rect_top;
        chain[0].rect_width  = rect_width;
        chain[0].rect_height = rect_height;
        chain[0].point_x     = point_x;
        chain[0].point_y     = point_y;
        chain[0].found       = 1'b0;
        chain[0].best_dist   = '0;
        chain[0].best_x      = point_x;
        chain[0].best_y      = point_y;
    end

    genvar k;
    generate
        for (k = 0; k < N; k++)
        begin : g_cell
            assign sel[k] = (chain[k].slot == npr_pkg::SLOT_BITS'(k));

            npr_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .advance (advance),
                .sel     (sel[k]),
                .tok_in  (chain[k]),
                .tok_out (chain[k+1])
            );
        end
    endgenerate

    assign last_query = chain[N].valid && (chain[N].cmd == npr_pkg::CMD_QUERY);

    // The whole row holds only while a finished query cannot enter the result register.
    assign advance   = !(last_query && rsp_valid_reg && rsp_stall);
    assign req_stall = !advance;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (advance && last_query)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && last_query)
        begin
            result_x_reg  <= chain[N].best_x;
            result_y_reg  <= chain[N].best_y;
            no_region_reg <= !chain[N].found;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign result_x  = result_x_reg;
    assign result_y  = result_y_reg;
    assign no_region = no_region_reg;

    a_stall_only_on_blocked_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        req_stall |-> (rsp_valid && rsp_stall)
    ) else $error("input stalled while the result register could move");

    a_unfound_keeps_point: assert property (
        @(posedge clk) disable iff (!rst_n)
        (last_query && !chain[N].found) |->
            ((chain[N].best_x == chain[N].point_x) && (chain[N].best_y == chain[N].point_y))
    ) else $error("query with no valid rectangle changed its point");

    a_query_reaches_output: assert property (
        @(posedge clk) disable iff (!rst_n)
        (last_query && advance) |=> rsp_valid
    ) else $error("finished query did not reach the result register");

endmodule

/* bench/nearest_point_in_rectangles_top_tb.sv */
// Testbench for the nearest point in rectangles block: random beats against a scoreboard.
module nearest_point_in_rectangles_top_tb;

    typedef logic [npr_pkg::CMD_BITS-1:0]          code_t;
    typedef logic [npr_pkg::SLOT_BITS-1:0]         slot_t;
    typedef logic signed [npr_pkg::COORD_BITS-1:0] coord_t;
    typedef logic [npr_pkg::SIZE_BITS-1:0]         extent_t;

    localparam code_t CMD_UNUSED  = 2'd3;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int DRAIN_CYCLES   = 3 * npr_pkg::REGION_SLOTS + 16;
    localparam int RANDOM_BEATS   = 750;
    localparam int REPORT_LIMIT   = 10;

    typedef struct {
        code_t   cmd;
        slot_t   slot;
        coord_t  left;
        coord_t  top;
        extent_t width;
        extent_t height;
        coord_t  px;
        coord_t  py;
    } beat_t;

    typedef struct {
        coord_t x;
        coord_t y;
        logic   empty;
    } nearest_t;

    class rect_scoreboard;
        longint rect_x0 [npr_pkg::REGION_SLOTS];
        longint rect_y0 [npr_pkg::REGION_SLOTS];
        longint rect_w  [npr_pkg::REGION_SLOTS];
        longint rect_h  [npr_pkg::REGION_SLOTS];
        bit     rect_live [npr_pkg::REGION_SLOTS];
        nearest_t nearest_q [$];
        int failures;

        function new();
            for (int i = 0; i < npr_pkg::REGION_SLOTS; i++)
            begin
                rect_x0[i]   = 0;
                rect_y0[i]   = 0;
                rect_w[i]    = 0;
                rect_h[i]    = 0;
                rect_live[i] = 0;
            end
            failures = 0;
        endfunction

        function longint pull_into_span(longint p, longint lo, longint size);
            longint hi;
            hi = lo + size - 1;
            if (p < lo)
                return lo;
            if (p > hi)
                return hi;
            return p;
        endfunction

        function void fail(string what);
            failures++;
            if (failures <= REPORT_LIMIT)
                $display("ERROR: %s", what);
        endfunction

        function void note_beat(beat_t b);
            longint px, py, nx, ny, dx, dy, d, best_d;
            nearest_t r;
            bit found;
            px     = longint'(b.px);
            py     = longint'(b.py);
            found  = 0;
            best_d = 0;
            case (b.cmd)
                npr_pkg::CMD_WRITE:
                begin
                    rect_x0[b.slot]   = longint'(b.left);
                    rect_y0[b.slot]   = longint'(b.top);
                    // A zero size is kept as a single pixel.
                    rect_w[b.slot]    = (b.width == 0) ? 1 : longint'(b.width);
                    rect_h[b.slot]    = (b.height == 0) ? 1 : longint'(b.height);
                    rect_live[b.slot] = 1;
                end
                npr_pkg::CMD_CLEAR:
                    rect_live[b.slot] = 0;
                npr_pkg::CMD_QUERY:
                begin
                    r.x = b.px;
                    r.y = b.py;
                    for (int i = 0; i < npr_pkg::REGION_SLOTS; i++)
                    begin
                        if (!rect_live[i])
                            continue;
                        nx = pull_into_span(px, rect_x0[i], rect_w[i]);
                        ny = pull_into_span(py, rect_y0[i], rect_h[i]);
                        dx = nx - px;
                        dy = ny - py;
                        d  = dx * dx + dy * dy;
                        // A later slot wins only on a strictly smaller distance.
                        if (!found || d < best_d)
                        begin
                            found  = 1;
                            best_d = d;
                            r.x    = nx[npr_pkg::COORD_BITS-1:0];
                            r.y    = ny[npr_pkg::COORD_BITS-1:0];
                        end
                        if (best_d == 0)
                            break;
                    end
                    r.empty = !found;
                    nearest_q.push_back(r);
                end
                default:
                    ;
            endcase
        endfunction

        function void check_result(coord_t x, coord_t y, logic empty);
            nearest_t e;
            if (nearest_q.size() == 0)
            begin
                fail($sformatf("result beat with none expected: x=%0d y=%0d no_region=%0b",
                               x, y, empty));
                return;
            end
            e = nearest_q.pop_front();
            if (x !== e.x || y !== e.y || empty !== e.empty)
                fail($sformatf("expected x=%0d y=%0d no_region=%0b, got x=%0d y=%0d no_region=%0b",
                               e.x, e.y, e.empty, x, y, empty));
        endfunction

        function int pending();
            return nearest_q.size();
        endfunction

        function void flush_leftover();
            nearest_t e;
            while (nearest_q.size() != 0)
            begin
                e = nearest_q.pop_front();
                fail($sformatf("missing result beat: x=%0d y=%0d no_region=%0b",
                               e.x, e.y, e.empty));
            end
        endfunction
    endclass

    logic    clk         = 1'b0;
    logic    rst_n       = 1'b0;
    logic    req_valid   = 1'b0;
    logic    req_stall;
    code_t   command     = CMD_UNUSED;
    slot_t   slot        = '0;
    coord_t  rect_left   = '0;
    coord_t  rect_top    = '0;
    extent_t rect_width  = '0;
    extent_t rect_height = '0;
    coord_t  point_x     = '0;
    coord_t  point_y     = '0;
    logic    rsp_valid;
    logic    rsp_stall   = 1'b0;
    coord_t  result_x;
    coord_t  result_y;
    logic    no_region;

    rect_scoreboard sb;
    int cycle_count = 0;
    int stall_mode  = 0;
    int mode_left   = 0;

    nearest_point_in_rectangles_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .command     (command),
        .slot        (slot),
        .rect_left   (rect_left),
        .rect_top    (rect_top),
        .rect_width  (rect_width),
        .rect_height (rect_height),
        .point_x     (point_x),
        .point_y     (point_y),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .result_x    (result_x),
        .result_y    (result_y),
        .no_region   (no_region)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver: check each accepted result beat, then pick the next stall value.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid === 1'b1 && !rsp_stall)
            sb.check_result(result_x, result_y, no_region);
        if (mode_left == 0)
        begin
            stall_mode <= int'($urandom_range(0, 3));
            mode_left  <= int'($urandom_range(10, 80));
        end
        else
            mode_left <= mode_left - 1;
        case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= 1'($urandom_range(0, 1));
            2:       rsp_stall <= (cycle_count % 32) < 24;
            default: rsp_stall <= ($urandom_range(0, 9) == 0);
        endcase
    end

    function automatic coord_t rand_coord();
        case ($urandom_range(0, 7))
            0:       return coord_t'(-32768);
            1:       return coord_t'(32767);
            2, 3:    return coord_t'($urandom);
            default: return coord_t'(int'($urandom_range(0, 200)) - 100);
        endcase
    endfunction

    function automatic extent_t rand_size();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 15'h7fff;
            2, 3:    return extent_t'($urandom);
            default: return extent_t'($urandom_range(1, 64));
        endcase
    endfunction

    // Fields that a command does not use are filled with noise.
    function automatic beat_t noise_beat(code_t cmd);
        beat_t b;
        b.cmd    = cmd;
        b.slot   = slot_t'($urandom);
        b.left   = coord_t'($urandom);
        b.top    = coord_t'($urandom);
        b.width  = extent_t'($urandom);
        b.height = extent_t'($urandom);
        b.px     = coord_t'($urandom);
        b.py     = coord_t'($urandom);
        return b;
    endfunction

    function automatic beat_t write_beat(int sl, int l, int t, int w, int h);
        beat_t b;
        b        = noise_beat(npr_pkg::CMD_WRITE);
        b.slot   = slot_t'(sl);
        b.left   = coord_t'(l);
        b.top    = coord_t'(t);
        b.width  = extent_t'(w);
        b.height = extent_t'(h);
        return b;
    endfunction

    function automatic beat_t clear_beat(int sl);
        beat_t b;
        b      = noise_beat(npr_pkg::CMD_CLEAR);
        b.slot = slot_t'(sl);
        return b;
    endfunction

    function automatic beat_t query_beat(int x, int y);
        beat_t b;
        b    = noise_beat(npr_pkg::CMD_QUERY);
        b.px = coord_t'(x);
        b.py = coord_t'(y);
        return b;
    endfunction

    // Valid stays high between back-to-back beats; the caller lowers it for a gap.
    task automatic send_beat(beat_t b);
        req_valid   <= 1'b1;
        command     <= b.cmd;
        slot        <= b.slot;
        rect_left   <= b.left;
        rect_top    <= b.top;
        rect_width  <= b.width;
        rect_height <= b.height;
        point_x     <= b.px;
        point_y     <= b.py;
        do
            @(posedge clk);
        while (req_stall !== 1'b0);
        sb.note_beat(b);
    endtask

    task automatic pause_sender(int gap);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_random_beat();
        int pick;
        pick = int'($urandom_range(0, 99));
        if (pick < 30)
            send_beat(write_beat(int'($urandom_range(0, npr_pkg::REGION_SLOTS - 1)),
                                 rand_coord(), rand_coord(), rand_size(), rand_size()));
        else if (pick < 40)
            send_beat(clear_beat(int'($urandom_range(0, npr_pkg::REGION_SLOTS - 1))));
        else if (pick < 95)
            send_beat(query_beat(rand_coord(), rand_coord()));
        else
            send_beat(noise_beat(CMD_UNUSED));
    endtask

    initial
    begin
        int sent;
        int burst;
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Empty table: the point comes back as is.
        send_beat(query_beat(-32768, 32767));
        send_beat(query_beat(32767, -32768));
        send_beat(noise_beat(CMD_UNUSED));
        send_beat(query_beat(5, 5));
        // Widest rectangle and far corners, where the squared distance passes 31 bits.
        send_beat(write_beat(0, -32768, -32768, 32767, 32767));
        send_beat(query_beat(-1, -1));
        send_beat(query_beat(32767, 32767));
        // Zero size is stored as one pixel.
        send_beat(write_beat(7, 32767, 32767, 0, 0));
        send_beat(query_beat(32767, 32767));
        send_beat(query_beat(-32768, -32768));
        pause_sender(3);
        send_beat(clear_beat(0));
        send_beat(clear_beat(7));
        send_beat(query_beat(0, 0));
        // Equal distances on both sides: the lower slot must win.
        send_beat(write_beat(1, 10, 0, 1, 1));
        send_beat(write_beat(3, -10, 0, 1, 1));
        send_beat(query_beat(0, 0));
        send_beat(write_beat(6, -5, 3, 10, 10));
        send_beat(noise_beat(CMD_UNUSED));
        send_beat(query_beat(0, 0));
        send_beat(write_beat(2, 100, 100, 15'h4000, 15'h2aaa));
        send_beat(query_beat(200, -32768));
        pause_sender(5);
        send_beat(clear_beat(1));
        send_beat(clear_beat(2));
        send_beat(clear_beat(3));
        send_beat(clear_beat(6));
        send_beat(query_beat(-7, 9));

        sent = 0;
        while (sent < RANDOM_BEATS)
        begin
            if ($urandom_range(0, 39) == 0)
            begin
                // Empty the whole table so the no-region case shows up again.
                for (int i = 0; i < npr_pkg::REGION_SLOTS; i++)
                    send_beat(clear_beat(i));
                send_beat(query_beat(rand_coord(), rand_coord()));
                sent += npr_pkg::REGION_SLOTS + 1;
            end
            burst = int'($urandom_range(1, 20));
            for (int i = 0; i < burst; i++)
                send_random_beat();
            sent += burst;
            case ($urandom_range(0, 3))
                0:       pause_sender(0);
                1:       pause_sender(int'($urandom_range(1, 3)));
                default: pause_sender(int'($urandom_range(1, 15)));
            endcase
        end
        req_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.flush_leftover();
        if (sb.failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/npr_pkg.sv
hw/rtl/npr_cell.sv
hw/rtl/nearest_point_in_rectangles_top.sv
bench/nearest_point_in_rectangles_top_tb.sv
